FILE: rtl/core/gdr_pkg.sv
// Gregorian date register: shared types, codes, constants and calendar functions.
// Used by every module of the block; has no dependencies.

package gdr_pkg;

  localparam logic [13:0] YEAR_MIN     = 14'd1900;
  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [4:0]  ADD_MAX      = 5'd27;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [8:0]  DAYS_COMMON  = 9'd365;
  localparam logic [4:0]  FEB_LEAP_DAY = 5'd29;
  localparam logic [3:0]  MONTH_JAN    = 4'd1;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [4:0]  DAY_FIRST    = 5'd1;
  // 25 * INV25 == 1 mod 2^14; y divisible by 25 iff y * INV25 mod 2^14 <= DIV25_LIMIT
  localparam logic [13:0] INV25        = 14'd7209;
  localparam logic [13:0] DIV25_LIMIT  = 14'd655;

  typedef enum logic [2:0] {
    REQ_LOAD      = 3'd0,
    REQ_SET_MONTH = 3'd1,
    REQ_SET_DAY   = 3'd2,
    REQ_SET_YEAR  = 3'd3,
    REQ_ADVANCE   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_YEAR  = 2'd1,
    ERR_MONTH = 2'd2,
    ERR_DAY   = 2'd3
  } err_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [13:0] year_in;
    logic [4:0]  days_to_add;
  } req_t;

  typedef struct packed {
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [13:0] cur_year;
    logic        is_leap;
    logic [8:0]  day_of_year;
    logic [8:0]  days_remaining;
    logic [1:0]  error_code;
  } rsp_t;

  function automatic logic gdr_is_leap(logic [13:0] y);
    logic [13:0] prod;
    logic        div25;
    prod  = 14'(y * INV25);
    div25 = (prod <= DIV25_LIMIT);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] gdr_month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] gdr_days_before(logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/gdr_in_stage.sv
// Gregorian date register: input register with valid/stall handshake.
// Depends on gdr_pkg for the request type.

module gdr_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  gdr_pkg::req_t req_i,
  input  logic          down_ready_i,
  output logic          valid_o,
  output gdr_pkg::req_t req_o
);
  import gdr_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;
  logic accept;

  assign req_stall_o = valid_q && !down_ready_i;
  assign accept      = req_valid_i && !req_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (down_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

FILE: rtl/core/gdr_update.sv
// Gregorian date register: stored date and the next-date logic for one request.
// Depends on gdr_pkg for types, codes and calendar functions.

module gdr_update (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  gdr_pkg::req_t req_i,
  output gdr_pkg::rsp_t rsp_o
);
  import gdr_pkg::*;

  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [13:0] year_q, year_d;
  logic        leap_q, leap_d;

  logic        leap_in, leap_nx;
  logic [13:0] year_nx;
  logic [4:0]  len_cur, len_in, add_sat;
  logic [5:0]  day_sum, day_wrap;
  logic [8:0]  doy, ylen;
  err_e        err;

  always_comb begin
    year_nx  = (year_q == YEAR_MAX) ? YEAR_MIN : year_q + 14'd1;
    leap_in  = gdr_is_leap(req_i.year_in);
    leap_nx  = gdr_is_leap(year_nx);
    len_cur  = gdr_month_len(month_q, leap_q);
    len_in   = gdr_month_len(req_i.month_in, leap_in);
    add_sat  = (req_i.days_to_add > ADD_MAX) ? ADD_MAX : req_i.days_to_add;
    day_sum  = {1'b0, day_q} + {1'b0, add_sat};
    day_wrap = day_sum - {1'b0, len_cur};

    month_d = month_q;
    day_d   = day_q;
    year_d  = year_q;
    leap_d  = leap_q;
    err     = ERR_OK;

    unique case (req_e'(req_i.req_type))
      REQ_LOAD: begin
        if (req_i.year_in < YEAR_MIN || req_i.year_in > YEAR_MAX) begin
          err = ERR_YEAR;
        end else if (req_i.month_in < MONTH_JAN || req_i.month_in > MONTH_DEC) begin
          err = ERR_MONTH;
        end else if (req_i.day_in < DAY_FIRST || req_i.day_in > len_in) begin
          err = ERR_DAY;
        end else begin
          year_d  = req_i.year_in;
          month_d = req_i.month_in;
          day_d   = req_i.day_in;
          leap_d  = leap_in;
        end
      end
      REQ_SET_MONTH: begin
        if (req_i.month_in >= MONTH_JAN && req_i.month_in <= MONTH_DEC) begin
          month_d = req_i.month_in;
        end else begin
          err = ERR_MONTH;
        end
      end
      REQ_SET_DAY: begin
        if (req_i.day_in >= DAY_FIRST && req_i.day_in <= len_cur) begin
          day_d = req_i.day_in;
        end else begin
          err = ERR_DAY;
        end
      end
      REQ_SET_YEAR: begin
        if (req_i.year_in >= YEAR_MIN && req_i.year_in <= YEAR_MAX) begin
          year_d = req_i.year_in;
          leap_d = leap_in;
          if (!leap_in && month_q == MONTH_FEB && day_q == FEB_LEAP_DAY) begin
            day_d = DAY_FIRST;
          end
        end else begin
          err = ERR_YEAR;
        end
      end
      REQ_ADVANCE: begin
        if (day_sum > {1'b0, len_cur}) begin
          day_d = day_wrap[4:0];
          if (month_q == MONTH_DEC) begin
            month_d = MONTH_JAN;
            year_d  = year_nx;
            leap_d  = leap_nx;
          end else begin
            month_d = month_q + 4'd1;
          end
        end else begin
          day_d = day_sum[4:0];
        end
      end
      default: begin
      end
    endcase

    doy  = gdr_days_before(month_d) + {4'b0, day_d}
         + {8'b0, (leap_d && month_d > MONTH_FEB)};
    ylen = leap_d ? DAYS_LEAP : DAYS_COMMON;

    rsp_o.cur_month      = month_d;
    rsp_o.cur_day        = day_d;
    rsp_o.cur_year       = year_d;
    rsp_o.is_leap        = leap_d;
    rsp_o.day_of_year    = doy;
    rsp_o.days_remaining = (doy <= ylen) ? ylen - doy : 9'd0;
    rsp_o.error_code     = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q <= MONTH_JAN;
      day_q   <= DAY_FIRST;
      year_q  <= YEAR_MIN;
      leap_q  <= 1'b0;
    end else if (fire_i) begin
      month_q <= month_d;
      day_q   <= day_d;
      year_q  <= year_d;
      leap_q  <= leap_d;
    end
  end

endmodule

FILE: rtl/core/gdr_out_stage.sv
// Gregorian date register: result register with valid/stall handshake.
// Depends on gdr_pkg for the result type.

module gdr_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  gdr_pkg::rsp_t rsp_i,
  output logic          ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output gdr_pkg::rsp_t rsp_o
);
  import gdr_pkg::*;

  logic valid_q, valid_d;
  rsp_t rsp_q;

  assign ready_o = !valid_q || !rsp_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (!rsp_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign rsp_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: rtl/core/gregorian_date_register_top.sv
// Gregorian date register: top level joining input register, date update and result register.
// Depends on gdr_pkg, gdr_in_stage, gdr_update and gdr_out_stage.
//
//   channel   direction   handshake                 payload
//   request   in          req_valid_i / req_stall_o req_i (gdr_pkg::req_t)
//   response  out         rsp_valid_o / rsp_stall_i rsp_o (gdr_pkg::rsp_t)
//
// One request per cycle sustained while responses do not stall; a response is valid once
// its request reaches the result register and is taken at an edge without a response stall.
// The date update for a request is done in the cycle in which it moves from the input
// register to the result register, so the next request sees the updated date.
// Reset sets the date to 1 January 1900 and empties both registers.
// A stalled response holds the result register; a new request is still taken while
// the input register is empty.

module gregorian_date_register_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  gdr_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output gdr_pkg::rsp_t rsp_o
);
  import gdr_pkg::*;

  logic valid_s1;
  req_t req_s1;
  rsp_t rsp_next;
  logic out_ready;
  logic fire;

  assign fire = valid_s1 && out_ready;

  gdr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_stall_o  (req_stall_o),
    .req_i        (req_i),
    .down_ready_i (out_ready),
    .valid_o      (valid_s1),
    .req_o        (req_s1)
  );

  gdr_update u_upd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_s1),
    .rsp_o  (rsp_next)
  );

  gdr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .rsp_i       (rsp_next),
    .ready_o     (out_ready),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: rtl/core/gdr_checker.sv
// Gregorian date register: port-level assertions and their bind to the top level.
// Depends on gdr_pkg and gregorian_date_register_top.

module gdr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_stall_o,
  input logic          rsp_valid_o,
  input logic          rsp_stall_i,
  input gdr_pkg::rsp_t rsp_o
);
  import gdr_pkg::*;

  logic req_take;
  assign req_take = req_valid_i && !req_stall_o;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("stalled response changed");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_take ##1 !rsp_stall_i) |=> rsp_valid_o)
    else $error("response missing two cycles after request");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.cur_month >= MONTH_JAN && rsp_o.cur_month <= MONTH_DEC
                    && rsp_o.cur_year >= YEAR_MIN && rsp_o.cur_year <= YEAR_MAX)
    else $error("stored date out of range");

  a_year_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.day_of_year + rsp_o.days_remaining)
                    == (rsp_o.is_leap ? DAYS_LEAP : DAYS_COMMON))
    else $error("day of year and days remaining disagree");

endmodule

bind gregorian_date_register_top gdr_checker u_gdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_stall_o (req_stall_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_stall_i (rsp_stall_i),
  .rsp_o       (rsp_o)
);
